>>> rtl/rv32i_execute_stage_unit_macros.svh
// ----------------------------------------------------------------------------
// RV32I execute stage assertion macros
// Shared concurrent assertion forms for the execute stage RTL. Synthesis
// builds define SYNTHESIS and get empty bodies.
// ----------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_STAGE_UNIT_MACROS_SVH
`define RV32I_EXECUTE_STAGE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define RV32EX_ASSERT_IMP(name, a_clk, a_rst_n, ante, cons) \
  name: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
    else $error("execute stage assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RV32EX_ASSERT_NXT(name, a_clk, a_rst_n, ante, cons) \
  name: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
    else $error("execute stage assertion failed");

`else

`define RV32EX_ASSERT_IMP(name, a_clk, a_rst_n, ante, cons)

`define RV32EX_ASSERT_NXT(name, a_clk, a_rst_n, ante, cons)

`endif

`endif

>>> rtl/rv32ex_pkg.sv
// ----------------------------------------------------------------------------
// RV32I execute stage package
// Command and function codes, fixed field widths and the structs that pass
// between the execute datapath and the stage control.
// ----------------------------------------------------------------------------
`default_nettype none

package rv32ex_pkg;

  // Fixed field widths.
  localparam int CMD_W     = 4;
  localparam int F3_W      = 3;
  localparam int REG_IDX_W = 5;
  localparam int REG_NUM   = 32;
  localparam int XLEN      = 32;
  localparam int IMM_W     = 20;
  localparam int PC_W      = 18;

  // Command codes; codes above CMD_JAL are invalid.
  localparam logic [CMD_W-1:0] CMD_OP     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_OP_IMM = 4'd1;
  localparam logic [CMD_W-1:0] CMD_JALR   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SYSTEM = 4'd4;
  localparam logic [CMD_W-1:0] CMD_STORE  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_BRANCH = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LUI    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_AUIPC  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_JAL    = 4'd9;

  // ALU function codes.
  localparam logic [F3_W-1:0] F3_ADD  = 3'd0;
  localparam logic [F3_W-1:0] F3_SLL  = 3'd1;
  localparam logic [F3_W-1:0] F3_SLT  = 3'd2;
  localparam logic [F3_W-1:0] F3_SLTU = 3'd3;
  localparam logic [F3_W-1:0] F3_XOR  = 3'd4;
  localparam logic [F3_W-1:0] F3_SR   = 3'd5;
  localparam logic [F3_W-1:0] F3_OR   = 3'd6;
  localparam logic [F3_W-1:0] F3_AND  = 3'd7;

  // Branch condition codes.
  localparam logic [F3_W-1:0] BR_EQ  = 3'd0;
  localparam logic [F3_W-1:0] BR_NE  = 3'd1;
  localparam logic [F3_W-1:0] BR_LT  = 3'd4;
  localparam logic [F3_W-1:0] BR_GE  = 3'd5;
  localparam logic [F3_W-1:0] BR_LTU = 3'd6;
  localparam logic [F3_W-1:0] BR_GEU = 3'd7;

  // Address constants.
  localparam logic [XLEN-1:0] JALR_MASK   = 32'hFFFF_FFFE;
  localparam int              UPPER_SHIFT = 12;
  localparam logic [XLEN-1:0] SEQ_STEP    = 32'd4;

  // Decoded instruction as held in the execute stage.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [F3_W-1:0]  func3;
    logic             alt_bit;
    logic [IMM_W-1:0] imm;
    logic [PC_W-1:0]  pc;
  } exe_op_t;

  // Execute result handed back to the stage control.
  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            rd_write;
    logic [XLEN-1:0] value;
  } exe_res_t;

endpackage

`default_nettype wire

>>> rtl/rv32ex_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rv32ex_alu.sv
// ----------------------------------------------------------------------------
// RV32I execute datapath
// Computes the result value, the register write qualifier and the next
// program counter of one instruction from its two source operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ex_alu #(
  parameter int CODE_ADDRESS_BITS = 18
) (
  input  wire rv32ex_pkg::exe_op_t                     op_i,
  input  wire logic [rv32ex_pkg::XLEN-1:0]            rs1_val,
  input  wire logic [rv32ex_pkg::XLEN-1:0]            rs2_val,
  output rv32ex_pkg::exe_res_t                         res_o
);

  // Code address mask, all ones when the code space covers the full word.
  localparam logic [rv32ex_pkg::XLEN:0]   CodeSpan = (rv32ex_pkg::XLEN + 1)'(1)
                                                     << CODE_ADDRESS_BITS;
  localparam logic [rv32ex_pkg::XLEN-1:0] CodeMask =
    rv32ex_pkg::XLEN'(CodeSpan - (rv32ex_pkg::XLEN + 1)'(1));

  logic [rv32ex_pkg::XLEN-1:0] imm32;
  logic [rv32ex_pkg::XLEN-1:0] pc32;
  logic [rv32ex_pkg::XLEN-1:0] seq_pc;
  logic [rv32ex_pkg::XLEN-1:0] rel_tgt;
  logic [rv32ex_pkg::XLEN-1:0] jalr_tgt;
  logic [rv32ex_pkg::XLEN-1:0] upper_imm;
  logic [rv32ex_pkg::XLEN-1:0] value;
  logic [rv32ex_pkg::XLEN-1:0] npc;
  logic [rv32ex_pkg::XLEN-1:0] npc_masked;
  logic                        taken;

  // Register and immediate ALU operations.
  function automatic logic [rv32ex_pkg::XLEN-1:0] alu_op(
    input logic [rv32ex_pkg::XLEN-1:0] a,
    input logic [rv32ex_pkg::XLEN-1:0] b,
    input logic [rv32ex_pkg::F3_W-1:0] f3,
    input logic                        alt,
    input logic                        reg_form
  );
    logic [4:0]                  sh;
    logic [rv32ex_pkg::XLEN-1:0] r;
    sh = b[4:0];
    unique case (f3)
      rv32ex_pkg::F3_ADD:  r = (reg_form && alt) ? a - b : a + b;
      rv32ex_pkg::F3_SLL:  r = a << sh;
      rv32ex_pkg::F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
      rv32ex_pkg::F3_SLTU: r = {31'd0, a < b};
      rv32ex_pkg::F3_XOR:  r = a ^ b;
      rv32ex_pkg::F3_SR:   r = alt ? rv32ex_pkg::XLEN'($signed(a) >>> sh) : a >> sh;
      rv32ex_pkg::F3_OR:   r = a | b;
      rv32ex_pkg::F3_AND:  r = a & b;
      default:             r = a & b;
    endcase
    return r;
  endfunction

  // Branch condition; the two unused codes never take the branch.
  function automatic logic br_cond(
    input logic [rv32ex_pkg::XLEN-1:0] a,
    input logic [rv32ex_pkg::XLEN-1:0] b,
    input logic [rv32ex_pkg::F3_W-1:0] f3
  );
    logic t;
    unique case (f3)
      rv32ex_pkg::BR_EQ:  t = (a == b);
      rv32ex_pkg::BR_NE:  t = (a != b);
      rv32ex_pkg::BR_LT:  t = ($signed(a) < $signed(b));
      rv32ex_pkg::BR_GE:  t = !($signed(a) < $signed(b));
      rv32ex_pkg::BR_LTU: t = (a < b);
      rv32ex_pkg::BR_GEU: t = (a >= b);
      default:            t = 1'b0;
    endcase
    return t;
  endfunction

  // Operand and address preparation.
  assign imm32     = {{(rv32ex_pkg::XLEN - rv32ex_pkg::IMM_W){op_i.imm[rv32ex_pkg::IMM_W-1]}},
                      op_i.imm};
  assign pc32      = {{(rv32ex_pkg::XLEN - rv32ex_pkg::PC_W){1'b0}}, op_i.pc} & CodeMask;
  assign seq_pc    = pc32 + rv32ex_pkg::SEQ_STEP;
  assign rel_tgt   = pc32 + {imm32[rv32ex_pkg::XLEN-2:0], 1'b0};
  assign jalr_tgt  = (rs1_val + imm32) & rv32ex_pkg::JALR_MASK;
  assign upper_imm = imm32 << rv32ex_pkg::UPPER_SHIFT;
  assign taken     = br_cond(rs1_val, rs2_val, op_i.func3);

  // Result and next address selection by command.
  always_comb begin
    value = '0;
    npc   = seq_pc;
    unique case (op_i.command)
      rv32ex_pkg::CMD_OP: begin
        value = alu_op(rs1_val, rs2_val, op_i.func3, op_i.alt_bit, 1'b1);
      end
      rv32ex_pkg::CMD_OP_IMM: begin
        value = alu_op(rs1_val, imm32, op_i.func3, op_i.alt_bit, 1'b0);
      end
      rv32ex_pkg::CMD_JALR: begin
        value = seq_pc;
        npc   = jalr_tgt;
      end
      rv32ex_pkg::CMD_LOAD, rv32ex_pkg::CMD_SYSTEM, rv32ex_pkg::CMD_STORE: begin
        value = '0;
      end
      rv32ex_pkg::CMD_BRANCH: begin
        value = {31'd0, taken};
        if (taken) begin
          npc = rel_tgt;
        end
      end
      rv32ex_pkg::CMD_LUI: begin
        value = upper_imm;
      end
      rv32ex_pkg::CMD_AUIPC: begin
        value = pc32 + upper_imm;
      end
      rv32ex_pkg::CMD_JAL: begin
        value = seq_pc;
        npc   = rel_tgt;
      end
      default: begin
        npc = '0;
      end
    endcase
  end

  assign npc_masked     = npc & CodeMask;
  assign res_o.next_pc  = npc_masked[rv32ex_pkg::PC_W-1:0];
  assign res_o.rd_write = (op_i.command != rv32ex_pkg::CMD_BRANCH) &&
                          (op_i.command != rv32ex_pkg::CMD_STORE);
  assign res_o.value    = value;

endmodule

`default_nettype wire

>>> rtl/rv32i_execute_stage_unit.sv
// An instruction passes through the stage 1 register, where the register file is read, then the output register.
// Throughput: one instruction per cycle unless the result channel stalls, set by the register file RAM ports.
// A younger instruction reading a register written by the one ahead of it
// gets the value through a bypass register, so no bubble is inserted.
// Reset (synchronous, active low) empties the pipeline and marks all
// registers as zero through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module rv32i_execute_stage_unit #(
  parameter int CODE_ADDRESS_BITS = 18
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Instruction channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_command,
  input  wire logic [2:0]  in_func3,
  input  wire logic        in_alt_bit,
  input  wire logic [4:0]  in_dest_index,
  input  wire logic [4:0]  in_source1_index,
  input  wire logic [4:0]  in_source2_index,
  input  wire logic signed [19:0] in_immediate,
  input  wire logic [17:0] in_pc,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [17:0]      out_next_pc,
  output logic             out_write_enable,
  output logic [4:0]       out_write_index,
  output logic signed [31:0] out_write_value
);

  localparam int IdxW = rv32ex_pkg::REG_IDX_W;
  localparam int XLen = rv32ex_pkg::XLEN;

  logic                   in_xfer;
  logic                   s1_adv;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  rv32ex_pkg::exe_op_t    s1_op_r;
  logic [IdxW-1:0]        s1_rd_r;
  logic [IdxW-1:0]        s1_rs1_r;
  logic [IdxW-1:0]        s1_rs2_r;
  logic [XLen-1:0]        ram_a_data;
  logic [XLen-1:0]        ram_b_data;
  logic [XLen-1:0]        rs1_val;
  logic [XLen-1:0]        rs2_val;
  rv32ex_pkg::exe_res_t   exe_res;
  logic                   rf_we;
  logic [IdxW-1:0]        rf_waddr;
  logic [XLen-1:0]        rf_wdata;
  logic [rv32ex_pkg::REG_NUM-1:0] valid_r;
  logic                   fwd_valid_r;
  logic [IdxW-1:0]        fwd_idx_r;
  logic [XLen-1:0]        fwd_data_r;
  logic                   out_load;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [17:0]            out_npc_r;
  logic                   out_we_r;
  logic [IdxW-1:0]        out_idx_r;
  logic [XLen-1:0]        out_value_r;

  // Handshake: stage 1 moves on when the output register is free or drains.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = s1_valid_r && s1_adv;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1 instruction fields, captured with the register file read.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r.command <= in_command;
      s1_op_r.func3   <= in_func3;
      s1_op_r.alt_bit <= in_alt_bit;
      s1_op_r.imm     <= in_immediate;
      s1_op_r.pc      <= in_pc;
      s1_rd_r         <= in_dest_index;
      s1_rs1_r        <= in_source1_index;
      s1_rs2_r        <= in_source2_index;
    end
  end

  // Register file: two copies so both sources are read in the same cycle.
  rv32ex_ram #(
    .WIDTH (XLen),
    .DEPTH (rv32ex_pkg::REG_NUM)
  ) u_rf_a (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (rf_waddr),
    .wr_data (rf_wdata),
    .rd_en   (in_xfer),
    .rd_addr (in_source1_index),
    .rd_data (ram_a_data)
  );

  rv32ex_ram #(
    .WIDTH (XLen),
    .DEPTH (rv32ex_pkg::REG_NUM)
  ) u_rf_b (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (rf_waddr),
    .wr_data (rf_wdata),
    .rd_en   (in_xfer),
    .rd_addr (in_source2_index),
    .rd_data (ram_b_data)
  );

  // Operand select: bypass of the write that coincided with the read, then
  // RAM data for written entries, else the reset value of zero.
  always_comb begin
    if (fwd_valid_r && (fwd_idx_r == s1_rs1_r)) begin
      rs1_val = fwd_data_r;
    end else if (valid_r[s1_rs1_r]) begin
      rs1_val = ram_a_data;
    end else begin
      rs1_val = '0;
    end
    if (fwd_valid_r && (fwd_idx_r == s1_rs2_r)) begin
      rs2_val = fwd_data_r;
    end else if (valid_r[s1_rs2_r]) begin
      rs2_val = ram_b_data;
    end else begin
      rs2_val = '0;
    end
  end

  // Execute datapath.
  rv32ex_alu #(
    .CODE_ADDRESS_BITS (CODE_ADDRESS_BITS)
  ) u_alu (
    .op_i    (s1_op_r),
    .rs1_val (rs1_val),
    .rs2_val (rs2_val),
    .res_o   (exe_res)
  );

  // Write back as the instruction leaves stage 1; x0 is never written.
  assign rf_we    = out_load && exe_res.rd_write && (s1_rd_r != '0);
  assign rf_waddr = s1_rd_r;
  assign rf_wdata = exe_res.value;

  // Written-entry flags and the bypass register of the latest write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else if (rf_we) begin
      valid_r[rf_waddr] <= 1'b1;
      fwd_valid_r       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      fwd_idx_r  <= rf_waddr;
      fwd_data_r <= rf_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_npc_r   <= exe_res.next_pc;
      out_we_r    <= exe_res.rd_write && (s1_rd_r != '0);
      out_idx_r   <= s1_rd_r;
      out_value_r <= exe_res.value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_npc_r;
  assign out_write_enable = out_we_r;
  assign out_write_index  = out_idx_r;
  assign out_write_value  = out_value_r;

  // Assertions.
`include "rv32i_execute_stage_unit_macros.svh"

  `RV32EX_ASSERT_IMP(a_x0_never_written, clk, rst_n, 1'b1, !valid_r[0])
  `RV32EX_ASSERT_NXT(a_fwd_tracks_write, clk, rst_n, rf_we,
    fwd_valid_r && (fwd_idx_r == $past(rf_waddr)) && (fwd_data_r == $past(rf_wdata)))
  `RV32EX_ASSERT_NXT(a_s1_holds_blocked, clk, rst_n, s1_valid_r && !s1_adv,
    s1_valid_r && $stable(s1_op_r) && $stable(s1_rd_r))
  `RV32EX_ASSERT_IMP(a_out_from_s1, clk, rst_n, $rose(out_valid_r), $past(s1_valid_r))

endmodule

`default_nettype wire
